// File: rtl/core/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by every other file in the project.
package rau_pkg;

    // Operand and result widths
    localparam int OP_W  = 16;
    localparam int PW    = 2 * OP_W;       // product / magnitude width
    localparam int AW    = PW + 1;         // shared unit width
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;
    localparam int CNT_W = $clog2(PW);

    // Command opcodes
    localparam logic [1:0] OPC_ADD = 2'd0;
    localparam logic [1:0] OPC_SUB = 2'd1;
    localparam logic [1:0] OPC_MUL = 2'd2;
    localparam logic [1:0] OPC_DIV = 2'd3;

    // Shared unit functions
    typedef logic [1:0] t_alu_op;
    localparam t_alu_op ALU_ADD = 2'd0;
    localparam t_alu_op ALU_SUB = 2'd1;
    localparam t_alu_op ALU_MUL = 2'd2;

    typedef struct packed {
        t_alu_op op;
    } t_alu_ctl;

    typedef struct packed {
        logic [1:0]             opcode;
        logic signed [OP_W-1:0] a_num;
        logic signed [OP_W-1:0] a_den;
        logic signed [OP_W-1:0] b_num;
        logic signed [OP_W-1:0] b_den;
    } t_cmd;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    error;
    } t_res;

endpackage

// File: rtl/core/rau_alu.sv
// Shared arithmetic unit: operand-wide multiply, add, and subtract with borrow.
// Depends on rau_pkg.
module rau_alu (
    input  rau_pkg::t_alu_ctl       i_ctl,
    input  logic [rau_pkg::AW-1:0]  i_x,
    input  logic [rau_pkg::AW-1:0]  i_y,
    output logic [rau_pkg::AW-1:0]  o_res,
    output logic                    o_borrow
);
    import rau_pkg::*;

    logic [PW-1:0] prod;
    logic [AW:0]   diff;
    logic [AW-1:0] sum;

    assign prod = PW'(i_x[OP_W-1:0]) * PW'(i_y[OP_W-1:0]);
    assign diff = {1'b0, i_x} - {1'b0, i_y};
    assign sum  = i_x + i_y;

    always_comb begin
        o_borrow = 1'b0;
        case (i_ctl.op)
            ALU_ADD: begin
                o_res = sum;
            end
            ALU_SUB: begin
                o_res    = diff[AW-1:0];
                o_borrow = diff[AW];
            end
            ALU_MUL: begin
                o_res = AW'(prod);
            end
            default: begin
                o_res = sum;
            end
        endcase
    end

endmodule

// File: rtl/core/rational_arithmetic_unit_core.sv
// Rational arithmetic unit: a op b on two signed fractions, reduced by GCD.
// Depends on rau_pkg and rau_alu.
//
// Usage: drive i_cmd (opcode, a_num, a_den, b_num, b_den) and raise start.
// The command transfers at a rising edge where start is high and busy is
// low. busy then stays high until the sequencer finishes; an error case
// leaves it low. The result shows on o_res for exactly one cycle with
// o_valid high; the receiver cannot stall it and must take it in that cycle.
// An error case (zero denominator, or divide by a zero fraction) shows its
// result the cycle after the transfer. A zero result shows after the
// multiply states and S_PREP (with S_SUM, and S_SWAP if taken, for add and
// subtract). Otherwise one item runs through two or three multiplies, a
// signed sum for add and subtract, a binary GCD loop with swaps, two
// restoring divides of PW quotient bits each and a final sign step, all on
// the one shared add/sub/mul unit.
// A new command can transfer in the cycle its predecessor's result shows.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// any pending result strobe.
module rational_arithmetic_unit_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  rau_pkg::t_cmd   i_cmd,
    output logic            o_valid,
    output rau_pkg::t_res   o_res
);
    import rau_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MULD = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_SWAP = 4'd5;
    localparam logic [3:0] S_PREP = 4'd6;
    localparam logic [3:0] S_GCD  = 4'd7;
    localparam logic [3:0] S_DIVN = 4'd8;
    localparam logic [3:0] S_DIVD = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    function automatic logic [OP_W-1:0] f_mag(input logic [OP_W-1:0] v);
        f_mag = v[OP_W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [3:0]       r_state, n_state;
    logic [1:0]       r_op, n_op;
    logic [OP_W-1:0]  r_an_m, n_an_m, r_ad_m, n_ad_m, r_bn_m, n_bn_m, r_bd_m, n_bd_m;
    logic             r_an_s, n_an_s, r_ad_s, n_ad_s, r_bn_s, n_bn_s, r_bd_s, n_bd_s;
    logic [PW-1:0]    r_nm, n_nm, r_dm, n_dm, r_p2, n_p2;
    logic             r_ns, n_ns, r_ds, n_ds, r_p2s, n_p2s;
    logic [PW-1:0]    r_u, n_u, r_v, n_v, r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_res             r_out, n_out;
    logic             r_out_vld, n_out_vld;

    t_alu_ctl         alu_ctl;
    logic [AW-1:0]    alu_x, alu_y, alu_res, num_full;
    logic             alu_borrow;
    logic             cmd_err;
    logic             cnt_last;

    rau_alu u_alu (
        .i_ctl    (alu_ctl),
        .i_x      (alu_x),
        .i_y      (alu_y),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_vld;
    assign o_res    = r_out;
    assign cnt_last = (r_cnt == CNT_W'(PW - 1));
    assign cmd_err  = (i_cmd.a_den == '0) || (i_cmd.b_den == '0)
                   || ((i_cmd.opcode == OPC_DIV) && (i_cmd.b_num == '0));

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_an_m    = r_an_m;
        n_ad_m    = r_ad_m;
        n_bn_m    = r_bn_m;
        n_bd_m    = r_bd_m;
        n_an_s    = r_an_s;
        n_ad_s    = r_ad_s;
        n_bn_s    = r_bn_s;
        n_bd_s    = r_bd_s;
        n_nm      = r_nm;
        n_dm      = r_dm;
        n_p2      = r_p2;
        n_ns      = r_ns;
        n_ds      = r_ds;
        n_p2s     = r_p2s;
        n_u       = r_u;
        n_v       = r_v;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_out     = r_out;
        n_out_vld = 1'b0;
        alu_ctl.op = ALU_SUB;
        alu_x     = '0;
        alu_y     = '0;
        num_full  = {1'b0, r_nm};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = i_cmd.opcode;
                    n_an_m = f_mag(i_cmd.a_num);
                    n_ad_m = f_mag(i_cmd.a_den);
                    n_bn_m = f_mag(i_cmd.b_num);
                    n_bd_m = f_mag(i_cmd.b_den);
                    n_an_s = i_cmd.a_num[OP_W-1];
                    n_ad_s = i_cmd.a_den[OP_W-1];
                    n_bn_s = i_cmd.b_num[OP_W-1];
                    n_bd_s = i_cmd.b_den[OP_W-1];
                    if (cmd_err) begin
                        n_out.res_num = '0;
                        n_out.res_den = '0;
                        n_out.error   = 1'b1;
                        n_out_vld     = 1'b1;
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                alu_ctl.op = ALU_MUL;
                alu_x = AW'(r_an_m);
                alu_y = (r_op == OPC_MUL) ? AW'(r_bn_m) : AW'(r_bd_m);
                n_nm  = alu_res[PW-1:0];
                n_ns  = r_an_s ^ ((r_op == OPC_MUL) ? r_bn_s : r_bd_s);
                n_state = ((r_op == OPC_ADD) || (r_op == OPC_SUB)) ? S_MUL2 : S_MULD;
            end
            S_MUL2: begin
                alu_ctl.op = ALU_MUL;
                alu_x = AW'(r_bn_m);
                alu_y = AW'(r_ad_m);
                n_p2  = alu_res[PW-1:0];
                // subtract flips the sign of the second cross product
                n_p2s = r_bn_s ^ r_ad_s ^ (r_op == OPC_SUB);
                n_state = S_MULD;
            end
            S_MULD: begin
                alu_ctl.op = ALU_MUL;
                alu_x = AW'(r_ad_m);
                alu_y = (r_op == OPC_DIV) ? AW'(r_bn_m) : AW'(r_bd_m);
                n_dm  = alu_res[PW-1:0];
                n_ds  = r_ad_s ^ ((r_op == OPC_DIV) ? r_bn_s : r_bd_s);
                n_state = ((r_op == OPC_ADD) || (r_op == OPC_SUB)) ? S_SUM : S_PREP;
            end
            S_SUM: begin
                alu_x = {1'b0, r_nm};
                alu_y = {1'b0, r_p2};
                if (r_ns == r_p2s) begin
                    alu_ctl.op = ALU_ADD;
                    n_nm    = alu_res[PW-1:0];
                    n_state = S_PREP;
                end else if (!alu_borrow) begin
                    n_nm    = alu_res[PW-1:0];
                    n_state = S_PREP;
                end else begin
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                alu_x   = {1'b0, r_p2};
                alu_y   = {1'b0, r_nm};
                n_nm    = alu_res[PW-1:0];
                n_ns    = r_p2s;
                n_state = S_PREP;
            end
            S_PREP: begin
                if (r_nm == '0) begin
                    n_out.res_num = '0;
                    n_out.res_den = DEN_W'(1);
                    n_out.error   = 1'b0;
                    n_out_vld     = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_u     = r_nm;
                    n_v     = r_dm;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                // binary GCD; common factors of two come straight off num and den
                alu_x = {1'b0, r_u};
                alu_y = {1'b0, r_v};
                if (!r_u[0] && !r_v[0]) begin
                    n_u  = {1'b0, r_u[PW-1:1]};
                    n_v  = {1'b0, r_v[PW-1:1]};
                    n_nm = {1'b0, r_nm[PW-1:1]};
                    n_dm = {1'b0, r_dm[PW-1:1]};
                end else if (!r_u[0]) begin
                    n_u = {1'b0, r_u[PW-1:1]};
                end else if (!r_v[0]) begin
                    n_v = {1'b0, r_v[PW-1:1]};
                end else if (alu_res == '0) begin
                    // odd GCD part stays in r_u as the divisor
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIVN;
                end else if (alu_borrow) begin
                    n_u = r_v;
                    n_v = r_u;
                end else begin
                    n_u = {1'b0, alu_res[PW-1:1]};
                end
            end
            S_DIVN, S_DIVD: begin
                // restoring divide; the dividend register shifts into the quotient
                if (r_state == S_DIVN) begin
                    alu_x = {r_rem, r_nm[PW-1]};
                end else begin
                    alu_x = {r_rem, r_dm[PW-1]};
                end
                alu_y = {1'b0, r_u};
                if (!alu_borrow) begin
                    n_rem = alu_res[PW-1:0];
                end else begin
                    n_rem = alu_x[PW-1:0];
                end
                if (r_state == S_DIVN) begin
                    n_nm = {r_nm[PW-2:0], ~alu_borrow};
                end else begin
                    n_dm = {r_dm[PW-2:0], ~alu_borrow};
                end
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = (r_state == S_DIVN) ? S_DIVD : S_FIN;
                end
            end
            S_FIN: begin
                alu_x = '0;
                alu_y = {1'b0, r_nm};
                if (r_ns ^ r_ds) begin
                    num_full = alu_res;
                end
                n_out.res_num = NUM_W'(signed'(num_full));
                n_out.res_den = DEN_W'(r_dm);
                n_out.error   = 1'b0;
                n_out_vld     = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_an_m <= n_an_m;
        r_ad_m <= n_ad_m;
        r_bn_m <= n_bn_m;
        r_bd_m <= n_bd_m;
        r_an_s <= n_an_s;
        r_ad_s <= n_ad_s;
        r_bn_s <= n_bn_s;
        r_bd_s <= n_bd_s;
        r_nm   <= n_nm;
        r_dm   <= n_dm;
        r_p2   <= n_p2;
        r_ns   <= n_ns;
        r_ds   <= n_ds;
        r_p2s  <= n_p2s;
        r_u    <= n_u;
        r_v    <= n_v;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
    end

endmodule

// File: dv/rau_checker.sv
`timescale 1ns / 1ps
// Result checker for rational_arithmetic_unit_core: predicts each reduced fraction
// from the accepted command and compares it with the strobed result. Depends on rau_pkg.
module rau_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  rau_pkg::t_cmd i_cmd,
    input  logic          i_valid,
    input  rau_pkg::t_res i_res,
    output int            o_mismatches,
    output int            o_pending,
    output int            o_checked,
    output int            o_err_results
);
    import rau_pkg::*;

    typedef struct {
        t_cmd cmd;
        t_res res;
    } t_fraction_exp;

    t_fraction_exp fraction_q[$];
    int mismatches  = 0;
    int pending_cnt = 0;
    int checked     = 0;
    int err_results = 0;

    assign o_mismatches  = mismatches;
    assign o_pending     = pending_cnt;
    assign o_checked     = checked;
    assign o_err_results = err_results;

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_res reduce_fraction(t_cmd c);
        t_res            r;
        longint          an, ad, bn, bd, num, den;
        longint unsigned mag_n, mag_d, g, qn, qd;
        logic [63:0]     signed_n;
        r  = '0;
        an = $signed(c.a_num);
        ad = $signed(c.a_den);
        bn = $signed(c.b_num);
        bd = $signed(c.b_den);
        if (ad == 0 || bd == 0 || (c.opcode == OPC_DIV && bn == 0)) begin
            r.error = 1'b1;
            return r;
        end
        case (c.opcode)
            OPC_ADD: begin
                num = an * bd + bn * ad;
                den = ad * bd;
            end
            OPC_SUB: begin
                num = an * bd - bn * ad;
                den = ad * bd;
            end
            OPC_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            default: begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        mag_n = (num < 0) ? -num : num;
        mag_d = (den < 0) ? -den : den;
        g     = euclid_gcd(mag_n, mag_d);
        qn    = mag_n / g;
        qd    = mag_d / g;
        if (qn == 0) begin
            r.res_den = DEN_W'(1);
        end else begin
            // move the sign into the numerator
            signed_n  = ((num < 0) != (den < 0)) ? -qn : qn;
            r.res_num = signed_n[NUM_W-1:0];
            r.res_den = qd[DEN_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : compare
        t_fraction_exp want;
        if (i_rst_n) begin
            // a result leaves before a command in the same cycle is queued
            if (i_valid) begin
                if (fraction_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: %0d/%0d err %0b",
                                 $realtime, $signed(i_res.res_num), i_res.res_den,
                                 i_res.error);
                end else begin
                    want = fraction_q.pop_front();
                    checked++;
                    if (i_res.error)
                        err_results++;
                    if (i_res.res_num !== want.res.res_num ||
                        i_res.res_den !== want.res.res_den ||
                        i_res.error !== want.res.error) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: op %0d  %0d/%0d , %0d/%0d", $realtime,
                                     want.cmd.opcode, $signed(want.cmd.a_num),
                                     $signed(want.cmd.a_den), $signed(want.cmd.b_num),
                                     $signed(want.cmd.b_den));
                            $display("    expected %0d/%0d err %0b  got %0d/%0d err %0b",
                                     $signed(want.res.res_num), want.res.res_den,
                                     want.res.error, $signed(i_res.res_num),
                                     i_res.res_den, i_res.error);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                want.cmd = i_cmd;
                want.res = reduce_fraction(i_cmd);
                fraction_q.push_back(want);
            end
            pending_cnt = fraction_q.size();
        end
    end

endmodule

// File: dv/tb_rational_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// Top of the rational arithmetic unit testbench: clock, reset, command stimulus in
// bursts and the verdict. Depends on rau_pkg, rational_arithmetic_unit_core, rau_checker.
module tb_rational_arithmetic_unit_core;
    import rau_pkg::*;

    localparam int RANDOM_CMDS  = 1600;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_valid;
    t_res o_res;

    int   mismatches, pending, checked, err_results;
    int   idle_cycles = 0;
    int   sent        = 0;
    t_cmd cmd_q[$];

    always #5 i_clk = ~i_clk;

    rational_arithmetic_unit_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    rau_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_cmd         (i_cmd),
        .i_valid       (o_valid),
        .i_res         (o_res),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_err_results (err_results)
    );

    function automatic t_cmd make_cmd(logic [1:0] op, int an, int ad, int bn, int bd);
        t_cmd c;
        c.opcode = op;
        c.a_num  = 16'(an);
        c.a_den  = 16'(ad);
        c.b_num  = 16'(bn);
        c.b_den  = 16'(bd);
        return c;
    endfunction

    // small values reduce often, edge values stress the widths
    function automatic int pick_operand(int mode);
        int v;
        case (mode)
            0: v = int'($urandom_range(0, 40)) - 20;
            1: begin
                case ($urandom_range(0, 7))
                    0: v = -32768;
                    1: v = -32767;
                    2: v = -1;
                    3: v = 0;
                    4: v = 1;
                    5: v = 32767;
                    6: v = 1 << $urandom_range(0, 14);
                    default: v = -(1 << $urandom_range(0, 15));
                endcase
            end
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return v;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   kind, mode;
        kind = $urandom_range(0, 99);
        mode = (kind < 40) ? 0 : (kind < 60) ? 1 : 2;
        c = make_cmd(2'($urandom_range(0, 3)), pick_operand(mode), pick_operand(mode),
                     pick_operand(mode), pick_operand(mode));
        // keep denominators nonzero except in the error classes
        while (c.a_den == 0)
            c.a_den = 16'(pick_operand(mode));
        while (c.b_den == 0)
            c.b_den = 16'(pick_operand(mode));
        if (kind < 3) begin
            if ($urandom_range(0, 1))
                c.a_den = '0;
            else
                c.b_den = '0;
        end else if (kind < 6) begin
            c.opcode = OPC_DIV;
            c.b_num  = '0;
        end
        return c;
    endfunction

    task automatic send_cmd(input t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        do
            @(posedge i_clk);
        while (busy);
        sent++;
    endtask

    // end the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("tb_rational_arithmetic_unit_core NOT OK");
            $finish;
        end
    end

    initial begin
        int burst;
        int gap;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;

        cmd_q.push_back(make_cmd(OPC_ADD, 1, 2, 1, 3));
        cmd_q.push_back(make_cmd(OPC_SUB, 1, 2, 1, 2));              // zero result
        cmd_q.push_back(make_cmd(OPC_MUL, -3, 4, 8, -9));
        cmd_q.push_back(make_cmd(OPC_DIV, 1, 2, 3, 4));
        cmd_q.push_back(make_cmd(OPC_ADD, -32768, -32768, -32768, -32768));
        cmd_q.push_back(make_cmd(OPC_ADD, -32768, 32767, -32768, 32767));
        cmd_q.push_back(make_cmd(OPC_MUL, -32768, 1, -32768, 1));
        cmd_q.push_back(make_cmd(OPC_SUB, 32767, -32768, -32768, 32767));
        cmd_q.push_back(make_cmd(OPC_DIV, -32768, 32767, 32767, -32768));
        cmd_q.push_back(make_cmd(OPC_ADD, 32767, 1, 32767, 1));
        cmd_q.push_back(make_cmd(OPC_SUB, 0, 1, 32767, 1));
        cmd_q.push_back(make_cmd(OPC_ADD, 5, 0, 1, 3));              // left denominator zero
        cmd_q.push_back(make_cmd(OPC_MUL, 5, 7, 1, 0));              // right denominator zero
        cmd_q.push_back(make_cmd(OPC_SUB, 1, 0, 1, 0));
        cmd_q.push_back(make_cmd(OPC_DIV, 7, 3, 0, 5));              // divide by zero
        cmd_q.push_back(make_cmd(OPC_DIV, -32768, -1, 0, -32768));
        cmd_q.push_back(make_cmd(OPC_DIV, 0, 9, -4, 3));             // zero dividend
        cmd_q.push_back(make_cmd(OPC_ADD, -1, -1, 0, -5));
        cmd_q.push_back(make_cmd(OPC_MUL, 0, -7, -5, 3));
        cmd_q.push_back(make_cmd(OPC_DIV, -1, 1, -1, 1));
        cmd_q.push_back(make_cmd(OPC_MUL, 6, -4, -10, 15));
        cmd_q.push_back(make_cmd(OPC_SUB, -32767, 32767, 32767, -32767));
        for (int i = 0; i < RANDOM_CMDS; i++)
            cmd_q.push_back(random_cmd());

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // back-to-back at first, then bursts with gaps that land on every phase
        while (cmd_q.size() > 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && cmd_q.size() > 0) begin
                send_cmd(cmd_q.pop_front());
                burst--;
            end
            gap = (sent < 200 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 180);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d commands sent, %0d results checked, %0d of them error results",
                 sent, checked, err_results);
        $display("%0d mismatches, %0d results still outstanding", mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("tb_rational_arithmetic_unit_core OK");
        else
            $display("tb_rational_arithmetic_unit_core NOT OK");
        $finish;
    end

endmodule

// File: rational_arithmetic_unit_core.f
rtl/core/rau_pkg.sv
rtl/core/rau_alu.sv
rtl/core/rational_arithmetic_unit_core.sv
dv/rau_checker.sv
dv/tb_rational_arithmetic_unit_core.sv
